FILE: design/rspe_pkg.sv
// ----------------------------------------------------------------------------
// rspe_pkg: shared GF(2^8) arithmetic for the Reed-Solomon parity encoder
// Field constants and a constant-free multiplier modulo x^8+x^4+x^3+x^2+1.
// ----------------------------------------------------------------------------
package rspe_pkg;

  typedef logic [7:0] gf_byte_t;

  // low byte of the field polynomial 0x11D
  localparam gf_byte_t GF_POLY_LOW = 8'h1D;
  // primitive element, also the step between generator roots
  localparam gf_byte_t GF_ALPHA    = 8'h02;
  localparam gf_byte_t GF_ONE      = 8'h01;

  // shift-and-add multiply, msb of b first
  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) begin
      acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY_LOW : 8'h00);
      if (b[k]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

endpackage

FILE: design/rspe_gen.sv
// ----------------------------------------------------------------------------
// rspe_gen: generator polynomial builder
// Holds the effective degree and rebuilds the generator coefficients one root
// per cycle after reset and after every degree write.
// ----------------------------------------------------------------------------
module rspe_gen #(
  parameter int MAX_DEGREE = 30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [4:0]                           cfg_wr_data,
  output logic [$clog2(MAX_DEGREE+1)-1:0]      degree,
  output logic [MAX_DEGREE-1:0][7:0]           coef,
  output logic                                 busy
);

  localparam int DW      = $clog2(MAX_DEGREE + 1);
  localparam int RST_DEG = (10 > MAX_DEGREE) ? MAX_DEGREE : 10;

  logic [DW-1:0]                 deg_r, deg_nxt;
  logic [DW-1:0]                 iter_r, iter_nxt;
  rspe_pkg::gf_byte_t            root_r, root_nxt;
  logic [MAX_DEGREE-1:0][7:0]    coef_r, coef_nxt;
  logic [MAX_DEGREE-1:0][7:0]    coef_step;
  logic [DW-1:0]                 wr_deg;
  logic [DW-1:0]                 start_deg;
  logic                          start;

  // written degree, zero taken as one, saturated at the maximum
  always_comb begin
    if (cfg_wr_data == 5'd0) begin
      wr_deg = DW'(1);
    end else if (int'(cfg_wr_data) > MAX_DEGREE) begin
      wr_deg = DW'(MAX_DEGREE);
    end else begin
      wr_deg = DW'(cfg_wr_data);
    end
  end

  assign start     = !rst_n || cfg_wr_en;
  assign start_deg = !rst_n ? DW'(RST_DEG) : wr_deg;

  // one root multiplied in: g[j] = g[j]*root + g[j+1]
  for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
    if (j < MAX_DEGREE - 1) begin : g_mid
      assign coef_step[j] = rspe_pkg::gf_mul(coef_r[j], root_r)
                          ^ ((j + 1 < int'(deg_r)) ? coef_r[j+1] : 8'h00);
    end else begin : g_top
      assign coef_step[j] = rspe_pkg::gf_mul(coef_r[j], root_r);
    end
  end

  // next state: seed on start, iterate while roots remain
  always_comb begin
    deg_nxt  = deg_r;
    iter_nxt = iter_r;
    root_nxt = root_r;
    coef_nxt = coef_r;
    if (start) begin
      deg_nxt  = start_deg;
      iter_nxt = start_deg;
      root_nxt = rspe_pkg::GF_ONE;
      for (int j = 0; j < MAX_DEGREE; j++) begin
        coef_nxt[j] = (j + 1 == int'(start_deg)) ? rspe_pkg::GF_ONE : 8'h00;
      end
    end else if (iter_r != '0) begin
      iter_nxt = iter_r - DW'(1);
      root_nxt = rspe_pkg::gf_mul(root_r, rspe_pkg::GF_ALPHA);
      coef_nxt = coef_step;
    end
  end

  // state registers (reset seeds the build through start)
  always_ff @(posedge clk) begin
    deg_r  <= deg_nxt;
    iter_r <= iter_nxt;
    root_r <= root_nxt;
    coef_r <= coef_nxt;
  end

  assign degree = deg_r;
  assign coef   = coef_r;
  assign busy   = (iter_r != '0);

endmodule

FILE: design/reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder: systematic RS parity over GF(2^8)
// Parallel LFSR division of each data byte by the generator polynomial; on a
// block end the remainder moves to a parity buffer that drains highest first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | in_data_byte[7:0], in_block_end
//  out_    | output    | out_valid/out_ready | out_parity_byte[7:0], out_parity_last
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data[4:0] (ecc_degree)
//
// One data byte per cycle while in_ready is high; one GF multiplier per LFSR tap.
// A block emits d parity bytes, one per cycle while out_ready is high, from a
// buffer apart from the LFSR, so the next block streams in during the drain; a
// block end stalls only while the previous block's parity is still draining (or
// the generator is busy). After reset and after each degree write, in_ready is
// low while the generator is built one root per cycle (d = effective degree).
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder #(
  parameter int MAX_DEGREE = 30
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_parity_byte,
  output logic       out_parity_last
);

  localparam int DW = $clog2(MAX_DEGREE + 1);

  logic [DW-1:0]               deg;
  logic [MAX_DEGREE-1:0][7:0]  gen_coef;
  logic                        gen_busy;

  logic [MAX_DEGREE-1:0][7:0]  rem_r, rem_nxt, rem_step;
  logic [MAX_DEGREE-1:0][7:0]  pbuf_r, pbuf_nxt, pbuf_shift;
  logic [DW-1:0]               cnt_r, cnt_nxt;
  rspe_pkg::gf_byte_t          factor;
  logic                        in_fire, out_fire, load, drain_busy;

  // generator builder
  rspe_gen #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .degree      (deg),
    .coef        (gen_coef),
    .busy        (gen_busy)
  );

  // handshakes
  assign out_fire   = out_valid && out_ready;
  assign drain_busy = (cnt_r != '0) && !(out_fire && out_parity_last);
  assign in_ready   = !gen_busy && !(in_block_end && drain_busy);
  assign in_fire    = in_valid && in_ready;
  assign load       = in_fire && in_block_end;

  // lfsr division step, taps past the degree stay zero
  assign factor = in_data_byte ^ rem_r[0];
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_lfsr
    if (i < MAX_DEGREE - 1) begin : g_mid
      assign rem_step[i] = ((i + 1 < int'(deg)) ? rem_r[i+1] : 8'h00)
                         ^ rspe_pkg::gf_mul(gen_coef[i], factor);
      assign pbuf_shift[i] = pbuf_r[i+1];
    end else begin : g_top
      assign rem_step[i]   = rspe_pkg::gf_mul(gen_coef[i], factor);
      assign pbuf_shift[i] = 8'h00;
    end
  end

  // remainder: cleared on degree write and after each block
  always_comb begin
    rem_nxt = rem_r;
    if (cfg_wr_en || load) begin
      rem_nxt = '0;
    end else if (in_fire) begin
      rem_nxt = rem_step;
    end
  end

  // parity buffer: load a finished block, shift out one byte per transaction
  always_comb begin
    pbuf_nxt = pbuf_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      pbuf_nxt = rem_step;
      cnt_nxt  = deg;
    end else if (out_fire) begin
      pbuf_nxt = pbuf_shift;
      cnt_nxt  = cnt_r - DW'(1);
    end
  end

  // control and remainder registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // parity payload
  always_ff @(posedge clk) begin
    pbuf_r <= pbuf_nxt;
  end

  assign out_valid       = (cnt_r != '0);
  assign out_parity_byte = pbuf_r[0];
  assign out_parity_last = (cnt_r == DW'(1));

endmodule

FILE: test/tb_reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// tb_reed_solomon_parity_encoder: self-checking bench for the RS parity encoder
// Streams data blocks through the input channel under random idling, predicts
// the parity of every block with a bench-side GF(2^8) LFSR divider and checks
// each parity transaction in order, across degree settings from 0 to 31.
// ----------------------------------------------------------------------------
module tb_reed_solomon_parity_encoder;

  localparam int MAX_DEGREE      = 30;
  localparam int DEGREE_AT_RESET = 10;
  // cycles allowed after the last parity byte before the block counts as idle
  localparam int SETTLE_CYCLES   = MAX_DEGREE + 10;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 400;
  // expected parity ring, far deeper than the few blocks that can be pending
  localparam int EXP_DEPTH       = 1024;

  typedef struct packed {
    rspe_pkg::gf_byte_t parity;
    logic               last;
  } parity_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = '0;
  logic       in_block_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_parity_byte;
  logic       out_parity_last;

  // bench copy of the encoder state
  logic [4:0]         degree_reg;
  rspe_pkg::gf_byte_t lfsr_rem  [MAX_DEGREE];
  rspe_pkg::gf_byte_t gen_coeff [MAX_DEGREE];
  parity_t            exp_mem   [EXP_DEPTH];
  parity_t            head_parity;
  int                 exp_wr = 0;
  int                 exp_rd = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ready_hold = 0;
  int cycle_count = 0;
  int errors = 0;
  int bytes_sent = 0;
  int blocks_sent = 0;
  int parity_checked = 0;
  int degree_writes = 0;

  reed_solomon_parity_encoder #(
    .MAX_DEGREE(MAX_DEGREE)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_parity_byte(out_parity_byte),
    .out_parity_last(out_parity_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parity predictor
  // ---------------------------------------------------------------------------

  // number of predicted parity bytes not yet checked
  function automatic int pending_count();
    return exp_wr - exp_rd;
  endfunction

  // gf(2^8) product, lsb of b first, reducing the running multiple of a
  function automatic rspe_pkg::gf_byte_t gf_times(input rspe_pkg::gf_byte_t a,
                                                  input rspe_pkg::gf_byte_t b);
    rspe_pkg::gf_byte_t prod;
    rspe_pkg::gf_byte_t mult;
    int k;
    prod = '0;
    mult = a;
    for (k = 0; k < 8; k++) begin
      if (b[k]) begin
        prod = prod ^ mult;
      end
      mult = {mult[6:0], 1'b0} ^ (mult[7] ? rspe_pkg::GF_POLY_LOW : 8'h00);
    end
    return prod;
  endfunction

  // degree register clamped to 1..MAX_DEGREE
  function automatic int active_degree();
    int d;
    d = int'(degree_reg);
    if (d < 1) begin
      d = 1;
    end
    if (d > MAX_DEGREE) begin
      d = MAX_DEGREE;
    end
    return d;
  endfunction

  // new degree: generator from roots 2^0..2^(d-1), remainder cleared
  function automatic void load_degree(input logic [4:0] value);
    int d;
    int i;
    int j;
    rspe_pkg::gf_byte_t root;
    degree_reg = value;
    d = active_degree();
    root = rspe_pkg::GF_ONE;
    for (i = 0; i < MAX_DEGREE; i++) begin
      gen_coeff[i] = '0;
      lfsr_rem[i] = '0;
    end
    gen_coeff[d - 1] = rspe_pkg::GF_ONE;
    for (i = 0; i < d; i++) begin
      for (j = 0; j < d; j++) begin
        gen_coeff[j] = gf_times(gen_coeff[j], root);
        if (j + 1 < d) begin
          gen_coeff[j] = gen_coeff[j] ^ gen_coeff[j + 1];
        end
      end
      root = gf_times(root, rspe_pkg::GF_ALPHA);
    end
  endfunction

  // one division step; a block end queues the whole remainder, highest first
  function automatic void absorb_byte(input rspe_pkg::gf_byte_t data, input logic last);
    int d;
    int i;
    rspe_pkg::gf_byte_t factor;
    parity_t p;
    d = active_degree();
    factor = data ^ lfsr_rem[0];
    for (i = 0; i + 1 < d; i++) begin
      lfsr_rem[i] = lfsr_rem[i + 1];
    end
    lfsr_rem[d - 1] = '0;
    for (i = 0; i < d; i++) begin
      lfsr_rem[i] = lfsr_rem[i] ^ gf_times(gen_coeff[i], factor);
    end
    if (last) begin
      for (i = 0; i < d; i++) begin
        p.parity = lfsr_rem[i];
        p.last = (i + 1 == d);
        exp_mem[exp_wr % EXP_DEPTH] = p;
        exp_wr++;
      end
      for (i = 0; i < MAX_DEGREE; i++) begin
        lfsr_rem[i] = '0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side and checking
  // ---------------------------------------------------------------------------

  // ready pattern: long hold when requested, random idling otherwise
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each parity transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_count() == 0) begin
        $error("parity transaction with nothing expected: byte %02h last %0b",
               out_parity_byte, out_parity_last);
        errors++;
      end else begin
        head_parity = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        parity_checked++;
        if (out_parity_byte !== head_parity.parity) begin
          $error("parity_byte mismatch: expected %02h actual %02h",
                 head_parity.parity, out_parity_byte);
          errors++;
        end
        if (out_parity_last !== head_parity.last) begin
          $error("parity_last mismatch: expected %0b actual %0b",
                 head_parity.last, out_parity_last);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d parity bytes outstanding",
               cycle_count, pending_count());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one data byte, with random idle cycles in front of it
  task automatic send_byte(input rspe_pkg::gf_byte_t data, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_block_end <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    absorb_byte(data, last);
    bytes_sent++;
    if (last) begin
      blocks_sent++;
    end
  endtask

  // wait until every predicted parity byte has come and the block settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(input logic [4:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    load_degree(value);
    degree_writes++;
  endtask

  // block of random bytes, last one marked as block end
  task automatic send_block(input int len);
    rspe_pkg::gf_byte_t data;
    int n;
    for (n = 0; n < len; n++) begin
      case ($urandom_range(7))
        0: data = 8'h00;
        1: data = 8'hFF;
        default: data = rspe_pkg::gf_byte_t'($urandom_range(255));
      endcase
      send_byte(data, n == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset degree of ten, no write, field extremes
  task automatic test_reset_degree();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // zero taken as one, the range ends, and 31 saturated to the maximum
  task automatic test_degree_extremes();
    write_degree(5'd0);
    send_byte(8'hA5, 1'b1);
    write_degree(5'd1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    write_degree(5'd30);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    write_degree(5'd31);
    send_byte(8'h12, 1'b1);
  endtask

  // a degree write in the middle of a block drops the partial remainder
  task automatic test_dropped_block();
    write_degree(5'd10);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    write_degree(5'd7);
    send_byte(8'h99, 1'b1);
  endtask

  // receiver stalls long while short blocks keep coming, then the parity drains; at degree 30, then at degree 4
  task automatic test_backpressure();
    int b;
    write_degree(5'd30);
    send_idle_pct = 0;
    recv_idle_pct = 20;
    ready_hold = HOLD_CYCLES;
    for (b = 0; b < 10; b++) begin
      send_block(2);
    end
    wait_idle();
    write_degree(5'd4);
    ready_hold = HOLD_CYCLES / 2;
    for (b = 0; b < 8; b++) begin
      send_block(1);
    end
    wait_idle();
  endtask

  // random blocks and degree changes under one idling setting
  task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int len;
    logic [4:0] deg;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0: deg = 5'd0;
            1: deg = 5'd1;
            2: deg = 5'd30;
            default: deg = 5'd31;
          endcase
        end else begin
          deg = 5'($urandom_range(2, 29));
        end
        write_degree(deg);
      end
      len = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
                                     : int'($urandom_range(1, 6));
      send_block(len);
      sent += len;
    end
  endtask

  initial begin
    load_degree(5'(DEGREE_AT_RESET));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 30;
    test_reset_degree();
    test_degree_extremes();
    test_dropped_block();
    test_backpressure();
    test_random(7, 71, 75);
    test_random(71, 7, 75);
    test_random(0, 0, 75);

    wait_idle();
    if (pending_count() != 0) begin
      $error("%0d predicted parity bytes never arrived", pending_count());
      errors++;
    end
    $display("sent %0d data bytes in %0d blocks over %0d degree writes (0..31)",
             bytes_sent, blocks_sent, degree_writes);
    $display("checked %0d parity bytes with idling, long stalls and drains, %0d errors",
             parity_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rspe_pkg.sv
design/rspe_gen.sv
design/reed_solomon_parity_encoder.sv
test/tb_reed_solomon_parity_encoder.sv
